>>> hdl/assert_macros.svh
// assertion macros used by pgcs_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PGCS_ASSERT(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define PGCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PGCS_ASSERT(lbl, clk, rst, expr)
`define PGCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/pgcs_pkg.sv
// shared types and constants of the polar grid smoother
`default_nettype none
package pgcs_pkg;
  localparam int ROWS_DEF       = 30;
  localparam int COLS_DEF       = 60;
  localparam int MAX_RADIUS_DEF = 8;
  localparam int Q_DEPTH        = 2;
  localparam int OUT_W          = 23;
  localparam logic [OUT_W-1:0] OUT_MAX = 23'h7fffff;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [4:0]  row;
    logic [5:0]  col;
    logic [15:0] value;
  } item_t;
endpackage
`default_nettype wire

>>> hdl/pgcs_front.sv
// command intake and short queue in front of the engine
`default_nettype none
module pgcs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire pgcs_pkg::item_t in_item,
  output logic               out_valid,
  output pgcs_pkg::item_t    out_item,
  input  wire logic          out_ready
);
  localparam int PTR_W = (pgcs_pkg::Q_DEPTH > 1) ? $clog2(pgcs_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(pgcs_pkg::Q_DEPTH + 1);

  pgcs_pkg::item_t q [pgcs_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign busy      = (count == CNT_W'(pgcs_pkg::Q_DEPTH));
  assign push      = start && !busy;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(pgcs_pkg::Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(pgcs_pkg::Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end
endmodule
`default_nettype wire

>>> hdl/pgcs_back.sv
// cell store, neighbourhood walk, multiply-accumulate and final divide
`default_nettype none
`include "assert_macros.svh"
module pgcs_back #(
  parameter int ROWS       = pgcs_pkg::ROWS_DEF,
  parameter int COLS       = pgcs_pkg::COLS_DEF,
  parameter int MAX_RADIUS = pgcs_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [3:0]                 radius,
  input  wire logic                       in_valid,
  input  wire pgcs_pkg::item_t            in_item,
  output logic                            in_ready,
  output logic                            done,
  output logic [pgcs_pkg::OUT_W-1:0]      smoothed
);
  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int WW    = $clog2(MAX_RADIUS + 2);
  localparam int IW    = $clog2(2 * MAX_RADIUS + 2);
  localparam int PW    = 2 * WW;
  localparam int ACC_W = 16 + 4 * WW;
  localparam int DCW   = $clog2(ACC_W + 1);
  localparam int HALF  = COLS / 2;
  localparam int OW    = pgcs_pkg::OUT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]       state;
  logic [WW-1:0]    rad;
  logic [WW-1:0]    cnt;
  logic [RW-1:0]    rcur;
  logic             dir;
  logic             flip;
  logic [CW-1:0]    cbase;
  logic [CW-1:0]    ccur;
  logic [IW-1:0]    ii;
  logic [IW-1:0]    jj;
  logic             p1_valid;
  logic [PW-1:0]    p1_w;
  logic             p2_valid;
  logic [PW+15:0]   p2_prod;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] quo;
  logic [PW:0]      rem;
  logic [PW-1:0]    divr;
  logic [DCW-1:0]   dcnt;

  logic [15:0]      mem [CELLS];
  logic [15:0]      rdata;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    scan_addr;
  logic             in_range;

  logic [RW-1:0]    dn_row;
  logic             dn_dir;
  logic             dn_flip;
  logic [RW-1:0]    up_row;
  logic             up_dir;
  logic             up_flip;
  logic [CW:0]      shifted;
  logic [CW-1:0]    start_flip;
  logic [CW-1:0]    start_up;
  logic [IW:0]      ii_ext;
  logic [IW:0]      jj_ext;
  logic [IW:0]      rad_ext;
  logic [IW:0]      wi_full;
  logic [IW:0]      wj_full;
  logic [WW-1:0]    radius_eff;
  logic [PW:0]      rem_sh;
  logic             ge;
  logic [ACC_W+OW-1:0] quo_ext;

  assign radius_eff = (int'(radius) > MAX_RADIUS) ? WW'(MAX_RADIUS) : WW'(radius);
  assign in_range   = (int'(in_item.row) < ROWS) && (int'(in_item.col) < COLS);
  assign wr_addr    = AW'(int'(in_item.row) * COLS + int'(in_item.col));
  assign scan_addr  = AW'(int'(rcur) * COLS + int'(ccur));
  assign in_ready   = (state == S_IDLE);
  assign mem_we     = in_ready && in_valid && (in_item.command == pgcs_pkg::CMD_WRITE) && in_range;
  assign mem_addr   = mem_we ? wr_addr : scan_addr;

  // virtual row minus one, reflecting at the poles
  always_comb begin
    dn_row  = rcur;
    dn_dir  = dir;
    dn_flip = flip;
    if (dir) begin
      if (rcur == '0) begin
        dn_dir  = 1'b0;
        dn_flip = !flip;
      end else begin
        dn_row = rcur - 1'b1;
      end
    end else begin
      if (rcur == RW'(ROWS - 1)) begin
        dn_dir  = 1'b1;
        dn_flip = !flip;
      end else begin
        dn_row = rcur + 1'b1;
      end
    end
  end

  // virtual row plus one
  always_comb begin
    up_row  = rcur;
    up_dir  = dir;
    up_flip = flip;
    if (dir) begin
      if (rcur == RW'(ROWS - 1)) begin
        up_dir  = 1'b0;
        up_flip = !flip;
      end else begin
        up_row = rcur + 1'b1;
      end
    end else begin
      if (rcur == '0) begin
        up_dir  = 1'b1;
        up_flip = !flip;
      end else begin
        up_row = rcur - 1'b1;
      end
    end
  end

  // first column of a row, moved by half the azimuth after a pole fold
  always_comb begin
    shifted = {1'b0, cbase} + (CW+1)'(HALF);
    if (int'(shifted) >= COLS) begin
      shifted = shifted - (CW+1)'(COLS);
    end
    start_flip = CW'(shifted);
    start_up   = up_flip ? start_flip : cbase;
  end

  always_comb begin
    ii_ext  = (IW+1)'(ii);
    jj_ext  = (IW+1)'(jj);
    rad_ext = (IW+1)'(rad);
    wi_full = (ii_ext < rad_ext) ? ii_ext + 1'b1 : (rad_ext << 1) + 1'b1 - ii_ext;
    wj_full = (jj_ext < rad_ext) ? jj_ext + 1'b1 : (rad_ext << 1) + 1'b1 - jj_ext;
  end

  always_comb begin
    rem_sh  = {rem[PW-1:0], quo[ACC_W-1]};
    ge      = (rem_sh >= {1'b0, divr});
    quo_ext = (ACC_W+OW)'(quo);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_item.value;
    end
    rdata <= mem[mem_addr];
  end

  // weight and product pipeline, accumulate after two stages
  always_ff @(posedge clk) begin
    p1_w    <= WW'(wi_full) * WW'(wj_full);
    p2_prod <= p1_w * rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      done     <= 1'b0;
      p1_valid <= (state == S_SCAN);
      p2_valid <= p1_valid;
      if (p2_valid) begin
        acc <= acc + ACC_W'(p2_prod);
      end
      case (state)
        S_IDLE: begin
          if (in_valid && (in_item.command == pgcs_pkg::CMD_READ)) begin
            if (in_range) begin
              rad   <= radius_eff;
              cnt   <= radius_eff;
              rcur  <= RW'(in_item.row);
              dir   <= 1'b1;
              flip  <= 1'b0;
              cbase <= CW'(in_item.col);
              acc   <= '0;
              state <= S_SETUP;
            end else begin
              quo   <= '0;
              state <= S_OUT;
            end
          end
        end
        S_SETUP: begin
          if (cnt == '0) begin
            ii    <= '0;
            jj    <= '0;
            ccur  <= flip ? start_flip : cbase;
            state <= S_SCAN;
          end else begin
            cnt   <= cnt - 1'b1;
            rcur  <= dn_row;
            dir   <= dn_dir;
            flip  <= dn_flip;
            cbase <= (cbase == '0) ? CW'(COLS - 1) : cbase - 1'b1;
          end
        end
        S_SCAN: begin
          if (jj_ext == (rad_ext << 1)) begin
            jj <= '0;
            if (ii_ext == (rad_ext << 1)) begin
              state <= S_DRAIN;
            end else begin
              ii   <= ii + 1'b1;
              rcur <= up_row;
              dir  <= up_dir;
              flip <= up_flip;
              ccur <= start_up;
            end
          end else begin
            jj   <= jj + 1'b1;
            ccur <= (ccur == CW'(COLS - 1)) ? '0 : ccur + 1'b1;
          end
        end
        S_DRAIN: begin
          divr <= (PW'(rad) + 1'b1) * (PW'(rad) + 1'b1);
          if (!p1_valid && !p2_valid) begin
            quo   <= acc;
            rem   <= '0;
            dcnt  <= DCW'(ACC_W);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? rem_sh - {1'b0, divr} : rem_sh;
          quo  <= {quo[ACC_W-2:0], ge};
          dcnt <= dcnt - 1'b1;
          if (dcnt == DCW'(1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          smoothed <= (quo_ext > (ACC_W+OW)'(pgcs_pkg::OUT_MAX)) ?
                      pgcs_pkg::OUT_MAX : quo_ext[OW-1:0];
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PGCS_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `PGCS_ASSERT(a_write_only_idle, clk, rst, !mem_we || (state == S_IDLE))
  `PGCS_ASSERT(a_div_after_drain, clk, rst, (state != S_DIV) || (!p1_valid && !p2_valid))
  `PGCS_ASSERT_NEXT(a_out_then_idle, clk, rst, state == S_OUT, (state == S_IDLE) && done)
endmodule
`default_nettype wire

>>> hdl/polar_grid_conic_smoother_core.sv
// top level: radius register, command queue and smoothing engine
// a read scans one cell per cycle on the single cell store port, and the
// bit-per-cycle divider then divides the weighted sum
// one item is worked on at a time; a two-word queue takes new commands meanwhile
// the result is shown one cycle with done high and cannot be stalled
// rst clears the radius, the queue and the engine; the cell store is undefined until written
`default_nettype none
module polar_grid_conic_smoother_core #(
  parameter int ROWS       = pgcs_pkg::ROWS_DEF,
  parameter int COLS       = pgcs_pkg::COLS_DEF,
  parameter int MAX_RADIUS = pgcs_pkg::MAX_RADIUS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [4:0]  row,
  input  wire logic [5:0]  col,
  input  wire logic [15:0] value,
  output logic             done,
  output logic [22:0]      smoothed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  radius
);
  logic [3:0]      radius_q;
  pgcs_pkg::item_t in_item;
  pgcs_pkg::item_t q_item;
  logic            q_valid;
  logic            q_ready;

  assign cfg_ready = 1'b1;
  assign in_item   = '{command: command, row: row, col: col, value: value};

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      radius_q <= radius;
    end
  end

  pgcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_item  (q_item),
    .out_ready (q_ready)
  );

  pgcs_back #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .radius   (radius_q),
    .in_valid (q_valid),
    .in_item  (q_item),
    .in_ready (q_ready),
    .done     (done),
    .smoothed (smoothed)
  );
endmodule
`default_nettype wire

>>> verif/polar_grid_conic_smoother_core_test.sv
// testbench of the polar grid smoother: random cell writes and smoothed reads checked per word
`timescale 1ns / 1ps
`default_nettype none
module polar_grid_conic_smoother_core_test;

  localparam int NR = pgcs_pkg::ROWS_DEF;
  localparam int NC = pgcs_pkg::COLS_DEF;
  localparam int QUIET_LIMIT = 5000;

  class smooth_board;
    logic [15:0] grid [NR][NC];
    logic [3:0]  rad;
    logic [22:0] pending [$];
    int          errors;
    int          reads;
    int          writes;

    function new();
      rad = 0;
      errors = 0;
      reads = 0;
      writes = 0;
    endfunction

    function logic [22:0] smooth_at(int r0, int c0);
      int     r;
      int     v;
      int     flips;
      int     shift;
      int     cc;
      longint sum;
      longint q;
      r = (rad > pgcs_pkg::MAX_RADIUS_DEF) ? pgcs_pkg::MAX_RADIUS_DEF : rad;
      sum = 0;
      for (int i = -r; i <= r; i++) begin
        v = r0 + i;
        flips = 0;
        // fold across the poles until the row lands in the grid
        while (v < 0 || v >= NR) begin
          if (v < 0) v = -v - 1;
          else v = 2 * NR - 1 - v;
          flips ^= 1;
        end
        shift = flips ? NC / 2 : 0;
        for (int j = -r; j <= r; j++) begin
          cc = ((c0 + j + shift) % NC + NC) % NC;
          sum += longint'(r + 1 - (i < 0 ? -i : i)) * longint'(r + 1 - (j < 0 ? -j : j))
                 * longint'(grid[v][cc]);
        end
      end
      q = sum / ((r + 1) * (r + 1));
      if (q > pgcs_pkg::OUT_MAX) q = pgcs_pkg::OUT_MAX;
      return q[22:0];
    endfunction

    function void note_item(pgcs_pkg::item_t it);
      bit in_range;
      in_range = it.row < NR && it.col < NC;
      if (it.command == pgcs_pkg::CMD_WRITE) begin
        writes++;
        if (in_range) grid[it.row][it.col] = it.value;
      end else begin
        reads++;
        pending.insert(pending.size(), in_range ? smooth_at(it.row, it.col) : '0);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [22:0] got);
      logic [22:0] want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word smoothed=%0d", got));
      end else begin
        want = pending.pop_front();
        if (got !== want) report($sformatf("smoothed=%0d expected %0d", got, want));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        command;
  logic [4:0]  row;
  logic [5:0]  col;
  logic [15:0] value;
  logic        done;
  logic [22:0] smoothed;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  radius;

  smooth_board board;
  int quiet;
  int idle_pct;

  polar_grid_conic_smoother_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .row(row), .col(col), .value(value),
    .done(done), .smoothed(smoothed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .radius(radius)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(smoothed);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL polar_grid_conic_smoother_core");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task send_item(logic cmd, logic [4:0] r, logic [5:0] c, logic [15:0] v);
    pgcs_pkg::item_t it;
    it.command = cmd;
    it.row = r;
    it.col = c;
    it.value = v;
    start <= 1'b1;
    command <= cmd;
    row <= r;
    col <= c;
    value <= v;
    do @(posedge clk); while (busy);
    board.note_item(it);
  endtask

  task sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    // writes may still be in the queue behind the last read
    repeat (20) @(posedge clk);
  endtask

  task set_radius(logic [3:0] v);
    cfg_valid <= 1'b1;
    radius <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.rad = v;
  endtask

  task corner_reads();
    send_item(pgcs_pkg::CMD_READ, 5'd0, 6'd0, '0);
    send_item(pgcs_pkg::CMD_READ, 5'(NR - 1), 6'(NC - 1), '0);
    send_item(pgcs_pkg::CMD_READ, 5'd0, 6'(NC / 2), '0);
    send_item(pgcs_pkg::CMD_READ, 5'(NR - 1), 6'd0, '0);
    send_item(pgcs_pkg::CMD_READ, 5'd1, 6'd1, 16'hffff);
  endtask

  task random_items(int n);
    logic [4:0] r;
    logic [5:0] c;
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      r = 5'($urandom_range(NR - 1));
      c = 6'($urandom_range(NC - 1));
      if (sel < 5) begin
        if ($urandom_range(1)) r = 5'($urandom_range(NR, 31));
        else c = 6'($urandom_range(NC, 63));
      end
      if (k == n / 2) drain();
      if (sel % 2) send_item(pgcs_pkg::CMD_READ, r, c, 16'($urandom));
      else send_item(pgcs_pkg::CMD_WRITE, r, c, 16'($urandom));
      sender_gap();
    end
  endtask

  initial begin
    board = new();
    rst <= 1'b1;
    start <= 1'b0;
    command <= pgcs_pkg::CMD_WRITE;
    row <= '0;
    col <= '0;
    value <= '0;
    cfg_valid <= 1'b0;
    radius <= '0;
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // whole grid first so no read ever sees an unwritten cell
    for (int r = 0; r < NR; r++)
      for (int c = 0; c < NC; c++)
        send_item(pgcs_pkg::CMD_WRITE, 5'(r), 6'(c),
                  (r + c) % 7 == 0 ? 16'hffff : 16'($urandom));

    send_item(pgcs_pkg::CMD_READ, 5'd3, 6'd5, '0);
    send_item(pgcs_pkg::CMD_WRITE, 5'd3, 6'd5, 16'h0000);
    send_item(pgcs_pkg::CMD_READ, 5'd3, 6'd5, '0);
    send_item(pgcs_pkg::CMD_WRITE, 5'd3, 6'd5, 16'hffff);
    send_item(pgcs_pkg::CMD_READ, 5'd3, 6'd5, '0);
    send_item(pgcs_pkg::CMD_WRITE, 5'd31, 6'd63, 16'h1234);
    send_item(pgcs_pkg::CMD_WRITE, 5'd4, 6'd60, 16'h1234);
    send_item(pgcs_pkg::CMD_WRITE, 5'd30, 6'd4, 16'h1234);
    send_item(pgcs_pkg::CMD_READ, 5'd31, 6'd63, '0);
    send_item(pgcs_pkg::CMD_READ, 5'd30, 6'd0, '0);
    send_item(pgcs_pkg::CMD_READ, 5'd5, 6'd60, '0);
    send_item(pgcs_pkg::CMD_READ, 5'd4, 6'd59, '0);
    corner_reads();
    drain();

    foreach (board.grid[r, c]) begin end
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin set_radius(4'd8);  idle_pct = 0;  end
        1: begin set_radius(4'd15); idle_pct = 83; end
        2: begin set_radius(4'd3);  idle_pct = 11; end
        3: begin set_radius(4'd1);  idle_pct = 0;  end
        default: begin set_radius(4'd0); idle_pct = 83; end
      endcase
      corner_reads();
      random_items(300);
      drain();
    end

    repeat (400) @(posedge clk);
    $display("covered %0d writes and %0d reads over radius 0, 1, 3, 8 and 15",
             board.writes, board.reads);
    $display("idle mixes 0/83/11 percent, pole folds, wrap and out-of-range addresses");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS polar_grid_conic_smoother_core");
    end else begin
      $display("FAIL polar_grid_conic_smoother_core");
    end
    $finish;
  end
endmodule
`default_nettype wire
